// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types, widths and helpers of the point-in-polygon test block.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  // Vertex table
  localparam int MaxCorners = 16;
  localparam int IdxW       = (MaxCorners > 1) ? $clog2(MaxCorners) : 1;
  localparam int CntW       = $clog2(MaxCorners + 1);

  // Fixed field widths
  localparam int CfgW  = 5;
  localparam int VidxW = 4;
  localparam int LatW  = 31;
  localparam int LonW  = 32;

  // Command queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    ActLoad = 1'b0,
    ActTest = 1'b1
  } action_e;

  typedef struct packed {
    action_e                action;
    logic [IdxW-1:0]        idx;
    logic [CntW-1:0]        count;
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Limit the programmed vertex count to the table depth.
  function automatic logic [CntW-1:0] clamp_count(input logic [CfgW-1:0] cnt);
    if (int'(cnt) > MaxCorners) begin
      return CntW'(MaxCorners);
    end
    return CntW'(cnt);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pip_in_if.sv =====
// ----------------------------------------------------------------------------
// pip_in_if
// Input channel: vertex loads and point tests, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_in_if import pip_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [VidxW-1:0]        vertex_index;
  logic signed [LatW-1:0]  lat;
  logic signed [LonW-1:0]  lon;

  modport source (output valid, output action, output vertex_index, output lat,
                  output lon, input ready);
  modport sink   (input valid, input action, input vertex_index, input lat,
                  input lon, output ready);
endinterface

`default_nettype wire

// ===== rtl/pip_out_if.sv =====
// ----------------------------------------------------------------------------
// pip_out_if
// Result channel: one inside flag per point test, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_out_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front
// Accepts input items, holds the vertex count register and classifies items
// into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_front import pip_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  pip_in_if.sink               in_i,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output cmd_t                 push_cmd_o
);

  logic [CfgW-1:0] corner_count_q;
  logic            accept;
  logic            slot_ok;
  action_e         act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_count_q <= '0;
    end else if (cfg_we_i) begin
      corner_count_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign act        = action_e'(in_i.action);
  assign slot_ok    = int'(in_i.vertex_index) < MaxCorners;

  // Drop loads aimed past the table; tests carry the clamped count along.
  assign push_o = accept && ((act == ActTest) || slot_ok);

  always_comb begin
    push_cmd_o.action = act;
    push_cmd_o.idx    = IdxW'(in_i.vertex_index);
    push_cmd_o.count  = clamp_count(corner_count_q);
    push_cmd_o.lat    = in_i.lat;
    push_cmd_o.lon    = in_i.lon;
  end

endmodule

`default_nettype wire

// ===== rtl/pip_queue.sv =====
// ----------------------------------------------------------------------------
// pip_queue
// Short command queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_queue import pip_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  output q_head_t   head_o,
  input  wire logic pop_i
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign full_o       = (int'(cnt_q) == QDepth);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (int'(wr_ptr_q) == QDepth - 1) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == QDepth - 1) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pip_walker.sv =====
// ----------------------------------------------------------------------------
// pip_walker
// Owns the vertex table, runs loads and walks polygon edges for tests
// through a read / difference / multiply / compare pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_walker import pip_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  q_head_t   head_i,
  output logic      pop_o,
  pip_out_if.source out_o
);

  localparam int DLatW = LatW + 1;
  localparam int DLonW = LonW + 1;
  localparam int ProdW = DLatW + DLonW;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StDone = 3'b100
  } walk_state_e;

  walk_state_e state_q, state_d;

  logic signed [LatW-1:0] lat_mem [MaxCorners];
  logic signed [LonW-1:0] lon_mem [MaxCorners];

  logic [IdxW-1:0]        i_q, i_d;
  logic [IdxW-1:0]        j_addr;
  logic [CntW-1:0]        n_q;
  logic                   iss_done_q, iss_done_d;
  logic                   inside_q, inside_d;
  logic signed [LatW-1:0] py_q;
  logic signed [LonW-1:0] px_q;

  logic issue, last_issue, start, wr_en;

  // Stage 1: table read data
  logic                   s1_v_q, s1_last_q;
  logic signed [LatW-1:0] s1_yi_q, s1_yj_q;
  logic signed [LonW-1:0] s1_xi_q, s1_xj_q;

  // Stage 2: conditions and differences
  logic                    s2_v_q, s2_last_q, s2_cand_q;
  logic signed [DLatW-1:0] s2_a_q, s2_d_q;
  logic signed [DLonW-1:0] s2_b_q, s2_c_q;
  logic                    cand_d;
  logic signed [DLatW-1:0] a_d, d_d;
  logic signed [DLonW-1:0] b_d, c_d;

  // Stage 3: cross products
  logic                    s3_v_q, s3_last_q, s3_cand_q, s3_dpos_q;
  logic signed [ProdW-1:0] s3_lhs_q, s3_rhs_q;
  logic                    hit;

  logic out_valid_q, out_valid_d, out_inside_q, out_load;

  assign pop_o  = (state_q == StIdle) && head_i.valid;
  assign start  = pop_o && (head_i.cmd.action == ActTest);
  assign wr_en  = pop_o && (head_i.cmd.action == ActLoad);
  assign issue  = (state_q == StWalk) && !iss_done_q;
  assign last_issue = (CntW'(i_q) == n_q - CntW'(1));
  // Edge i runs back to vertex i-1, wrapping to the last vertex in use.
  assign j_addr = (i_q == '0) ? IdxW'(n_q - CntW'(1)) : i_q - IdxW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lat_mem[head_i.cmd.idx] <= head_i.cmd.lat;
      lon_mem[head_i.cmd.idx] <= head_i.cmd.lon;
    end
    if (issue) begin
      s1_yi_q <= lat_mem[i_q];
      s1_xi_q <= lon_mem[i_q];
      s1_yj_q <= lat_mem[j_addr];
      s1_xj_q <= lon_mem[j_addr];
    end
  end

  always_comb begin
    cand_d = ((s1_yi_q < py_q) && (s1_yj_q >= py_q)) ||
             ((s1_yj_q < py_q) && (s1_yi_q >= py_q));
    cand_d = cand_d && ((s1_xi_q <= px_q) || (s1_xj_q <= px_q));
    d_d = $signed({s1_yj_q[LatW-1], s1_yj_q}) - $signed({s1_yi_q[LatW-1], s1_yi_q});
    a_d = $signed({py_q[LatW-1], py_q}) - $signed({s1_yi_q[LatW-1], s1_yi_q});
    b_d = $signed({s1_xj_q[LonW-1], s1_xj_q}) - $signed({s1_xi_q[LonW-1], s1_xi_q});
    c_d = $signed({px_q[LonW-1], px_q}) - $signed({s1_xi_q[LonW-1], s1_xi_q});
  end

  always_ff @(posedge clk_i) begin
    s2_cand_q <= cand_d;
    s2_a_q    <= a_d;
    s2_b_q    <= b_d;
    s2_c_q    <= c_d;
    s2_d_q    <= d_d;
    s3_cand_q <= s2_cand_q;
    s3_dpos_q <= !s2_d_q[DLatW-1] && (s2_d_q != '0);
    s3_lhs_q  <= s2_a_q * s2_b_q;
    s3_rhs_q  <= s2_c_q * s2_d_q;
  end

  // Comparison direction follows the sign of the latitude difference.
  assign hit = s3_cand_q && (s3_dpos_q ? (s3_lhs_q < s3_rhs_q) : (s3_lhs_q > s3_rhs_q));

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    iss_done_d = iss_done_q;
    inside_d   = inside_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          i_d        = '0;
          iss_done_d = 1'b0;
          inside_d   = 1'b0;
          state_d    = (head_i.cmd.count == '0) ? StDone : StWalk;
        end
      end
      StWalk: begin
        if (issue) begin
          if (last_issue) begin
            iss_done_d = 1'b1;
          end else begin
            i_d = i_q + IdxW'(1);
          end
        end
        if (s3_v_q) begin
          inside_d = inside_q ^ hit;
          if (s3_last_q) begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_load    = (state_q == StDone) && (!out_valid_q || out_o.ready);
  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      i_q         <= '0;
      iss_done_q  <= 1'b0;
      inside_q    <= 1'b0;
      s1_v_q      <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_v_q      <= 1'b0;
      s2_last_q   <= 1'b0;
      s3_v_q      <= 1'b0;
      s3_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      iss_done_q  <= iss_done_d;
      inside_q    <= inside_d;
      s1_v_q      <= issue;
      s1_last_q   <= issue && last_issue;
      s2_v_q      <= s1_v_q;
      s2_last_q   <= s1_last_q;
      s3_v_q      <= s2_v_q;
      s3_last_q   <= s2_last_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      n_q  <= head_i.cmd.count;
      py_q <= head_i.cmd.lat;
      px_q <= head_i.cmd.lon;
    end
    if (out_load) begin
      out_inside_q <= inside_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = out_inside_q;

endmodule

`default_nettype wire

// ===== rtl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number point-in-polygon test over a loadable vertex table.
// ----------------------------------------------------------------------------
// Load items (action 0) write one vertex into the table; a load to a slot at
// or past the table depth is dropped. Test items (action 1) return one
// inside flag under the even-odd rule, using the first corner_count vertices
// (clamped to the table depth). Coordinates are signed 1e-7 degree units and
// the crossing check is exact: the edge's crossing longitude is compared by
// cross-multiplication, never divided out. A front stage takes items into a
// two-entry command queue while the back end works, so the input takes up to
// two more items while a test runs or a result waits to be taken, and closes
// once the queue is full. A load is written into the table as it leaves the
// queue head. For a test, the edge walker reads one edge per cycle from the
// two-read vertex table; each edge then goes through registered differences,
// the two 32x33 cross products and the final compare, and the resulting flag
// is loaded into the output register.
// With fewer than three vertices the test reports outside. Reading a table
// slot that was never loaded gives an undefined flag. Write corner_count only
// while the block is idle.
`default_nettype none

module point_in_polygon_test import pip_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  pip_in_if.sink               in_i,
  pip_out_if.source            out_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i
);

  // Front to queue
  logic    push;
  cmd_t    push_cmd;
  logic    q_full;

  // Queue to back
  q_head_t q_head;
  logic    q_pop;

  // Accept items, hold the vertex count, drop out-of-range loads.
  pip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  // Decouple intake from the edge walk.
  pip_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  // Execute loads and tests; drive the result register.
  pip_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/pip_checker.sv =====
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks of the point-in-polygon test block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_inside_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_inside_i))
    else $error("result changed while stalled");

  // No result can appear right after reset release.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(rst_ni, 1) && $past(rst_ni, 2))
    else $error("result without time to compute it");

  // Input closes only when the queue fills on an accepted item.
  a_ready_falls_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("input ready dropped without an accepted item");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_inside_i (out_o.inside_res)
);

`default_nettype wire

// ===== sim/inside_checker.sv =====
// ----------------------------------------------------------------------------
// inside_checker
// Watches the item and result channels of the point-in-polygon block, keeps a
// shadow vertex table and corner count, predicts each inside flag and
// compares it with the flag that the block returns.
// ----------------------------------------------------------------------------
module inside_checker import pip_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  pip_in_if                    in_mon,
  pip_out_if                   out_mon,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [LatW-1:0] lat_shadow [MaxCorners];
  logic signed [LonW-1:0] lon_shadow [MaxCorners];
  logic [CfgW-1:0]        corner_count;
  bit                     inside_expected_q [$];

  // Exact crossing test of one edge; the division is folded into a compare.
  function automatic bit edge_toggles(longint py, longint px, longint yi, longint xi,
                                      longint yj, longint xj);
    longint dy;
    longint lhs;
    longint rhs;
    bit     straddle;
    straddle = (yi < py && yj >= py) || (yj < py && yi >= py);
    if (!straddle || !(xi <= px || xj <= px)) begin
      return 1'b0;
    end
    dy  = yj - yi;
    lhs = (py - yi) * (xj - xi);
    rhs = (px - xi) * dy;
    if (dy > 0) begin
      return lhs < rhs;
    end
    return lhs > rhs;
  endfunction

  function automatic bit predict_inside(longint py, longint px);
    int n;
    int j;
    bit flag;
    n    = (int'(corner_count) > MaxCorners) ? MaxCorners : int'(corner_count);
    flag = 1'b0;
    j    = n - 1;
    for (int i = 0; i < n; i++) begin
      if (edge_toggles(py, px, longint'(lat_shadow[i]), longint'(lon_shadow[i]),
                       longint'(lat_shadow[j]), longint'(lon_shadow[j]))) begin
        flag = ~flag;
      end
      j = i;
    end
    return flag;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      corner_count = '0;
      inside_expected_q.delete();
      pending_o = 0;
    end else begin
      // Check results before taking new items, so a stray flag never meets
      // an expectation queued at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (inside_expected_q.size() == 0) begin
          $display("%0t: unexpected inside_res, expected none actual %0b",
                   $time, out_mon.inside_res);
          fail_count_o++;
        end else begin
          want = inside_expected_q.pop_front();
          if (out_mon.inside_res !== want) begin
            $display("%0t: inside_res mismatch, expected %0b actual %0b",
                     $time, want, out_mon.inside_res);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        corner_count = cfg_wdata_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ActTest) begin
          inside_expected_q.push_back(predict_inside(longint'(in_mon.lat),
                                                     longint'(in_mon.lon)));
        end else if (int'(in_mon.vertex_index) < MaxCorners) begin
          lat_shadow[in_mon.vertex_index] = in_mon.lat;
          lon_shadow[in_mon.vertex_index] = in_mon.lon;
        end
      end
      pending_o = inside_expected_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Regression of the crossing-number point-in-polygon block: directed corner
// cases, then phases of random polygons and point tests at several corner
// counts, with random idling on both channels and a checker alongside.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  // Field extremes, in 1e-7 degree units at the full port widths
  localparam longint LatMin = -1073741824;
  localparam longint LatMax = 1073741823;
  localparam longint LonMin = -2147483648;
  localparam longint LonMax = 2147483647;

  // Cycles to let the back end settle once no flag is outstanding
  localparam int SettleCycles = 30;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;
  int              fail_count;
  int              pending;
  bit              steady;

  pip_in_if  in_ch ();
  pip_out_if out_ch ();

  point_in_polygon_test dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  inside_checker u_inside_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Current polygon as loaded, used to aim test points at its features
  logic signed [LatW-1:0] shape_lat [MaxCorners];
  logic signed [LonW-1:0] shape_lon [MaxCorners];
  longint                 shape_mid_lat;
  longint                 shape_mid_lon;
  longint                 shape_span;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: stall in about a quarter of the cycles, never while steady.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  // Uniform value within c +/- s; s stays at or below 2^30.
  function automatic longint near(longint c, longint s);
    return c + longint'($urandom_range(0, 32'(2 * s))) - s;
  endfunction

  // Offer one item from a falling edge and hold it until accepted; return at
  // the falling edge after the handshake with valid still high.
  task automatic send_item(action_e act, logic [VidxW-1:0] idx,
                           logic signed [LatW-1:0] la, logic signed [LonW-1:0] lo);
    if (!steady) begin
      while ($urandom_range(0, 99) < 26) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.vertex_index <= idx;
    in_ch.lat          <= la;
    in_ch.lon          <= lo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding flag, then let loads retire.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write corner_count only with the block idle.
  task automatic set_corners(logic [CfgW-1:0] cnt);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_vertex(int slot, logic signed [LatW-1:0] la,
                             logic signed [LonW-1:0] lo);
    shape_lat[slot] = la;
    shape_lon[slot] = lo;
    send_item(ActLoad, VidxW'(slot), la, lo);
  endtask

  // Pick a polygon of n corners: mostly a cluster of random size somewhere on
  // the globe, sometimes corners over the whole field range, with horizontal
  // edges thrown in now and then.
  task automatic build_shape(int n);
    bit     wide;
    longint la;
    longint lo;
    wide = ($urandom_range(0, 9) < 2);
    if (wide) begin
      shape_mid_lat = 0;
      shape_mid_lon = 0;
      shape_span    = longint'(1) << 30;
    end else begin
      shape_span    = longint'(1) << $urandom_range(3, 28);
      shape_mid_lat = near(0, longint'(1) << 29);
      shape_mid_lon = near(0, longint'(1) << 30);
    end
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        la = longint'($urandom);
        lo = longint'($urandom);
      end else begin
        la = near(shape_mid_lat, shape_span);
        lo = near(shape_mid_lon, shape_span);
      end
      if (i > 0 && $urandom_range(0, 5) == 0) begin
        la = longint'(shape_lat[i-1]);
      end
      load_vertex(i, LatW'(la), LonW'(lo));
    end
  endtask

  // Aim a test point at the polygon: in or near its box, on a corner's latitude or
  // longitude, on a corner, on an edge midpoint, or anywhere at all.
  task automatic pick_point(int n, output logic signed [LatW-1:0] la,
                            output logic signed [LonW-1:0] lo);
    int     mode;
    int     k;
    int     k2;
    longint s;
    mode = $urandom_range(0, 99);
    s    = shape_span + shape_span / 4;
    if (s > (longint'(1) << 30)) begin
      s = longint'(1) << 30;
    end
    la = LatW'(near(shape_mid_lat, s));
    lo = LonW'(near(shape_mid_lon, s));
    if (n > 0) begin
      k  = $urandom_range(0, n - 1);
      k2 = (k == 0) ? n - 1 : k - 1;
      if (mode >= 40 && mode < 60) begin
        la = shape_lat[k];
      end else if (mode >= 60 && mode < 70) begin
        lo = shape_lon[k];
      end else if (mode >= 70 && mode < 78) begin
        la = shape_lat[k];
        lo = shape_lon[k];
      end else if (mode >= 78 && mode < 88) begin
        la = LatW'((longint'(shape_lat[k]) + longint'(shape_lat[k2])) >>> 1);
        lo = LonW'((longint'(shape_lon[k]) + longint'(shape_lon[k2])) >>> 1);
      end
    end
    if (mode >= 88) begin
      la = LatW'($urandom);
      lo = LonW'($urandom);
    end
  endtask

  initial begin
    int                     plan [12];
    int                     n;
    int                     slot;
    logic signed [LatW-1:0] la;
    logic signed [LonW-1:0] lo;

    plan = '{3, 16, 31, 0, 5, 2, 17, 8, 1, 12, 4, 16};

    // Hold every input at a known value through reset.
    steady             = 1'b0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ActLoad;
    in_ch.vertex_index <= '0;
    in_ch.lat          <= '0;
    in_ch.lon          <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty polygon straight from reset reads no table slot.
    send_item(ActTest, 4'd0, 31'sd0, 32'sd0);

    // Square on the field extremes; products reach their widest here.
    load_vertex(0, LatW'(LatMin), LonW'(LonMin));
    load_vertex(1, LatW'(LatMin), LonW'(LonMax));
    load_vertex(2, LatW'(LatMax), LonW'(LonMax));
    load_vertex(3, LatW'(LatMax), LonW'(LonMin));
    set_corners(5'd4);
    send_item(ActTest, 4'd15, 31'sd0, 32'sd0);
    send_item(ActTest, 4'd0, LatW'(LatMax), 32'sd0);
    send_item(ActTest, 4'd0, LatW'(LatMin), 32'sd0);
    send_item(ActTest, 4'd0, 31'sd0, LonW'(LonMax));
    send_item(ActTest, 4'd0, 31'sd0, LonW'(LonMin));
    send_item(ActTest, 4'd0, LatW'(LatMax), LonW'(LonMax));
    send_item(ActTest, 4'd0, LatW'(LatMin), LonW'(LonMin));

    // Degenerate polygons of one and two corners report outside.
    set_corners(5'd1);
    send_item(ActTest, 4'd0, 31'sd0, 32'sd0);
    set_corners(5'd2);
    send_item(ActTest, 4'd0, LatW'(LatMin), 32'sd0);

    // Random phases, each at its own corner count. Load the polygon first so
    // no test ever reads a slot that was never written.
    for (int p = 0; p < 12; p++) begin
      set_corners(5'(plan[p]));
      steady = (p == 2);
      n = (plan[p] > MaxCorners) ? MaxCorners : plan[p];
      build_shape(n);
      for (int it = 0; it < 70 - n; it++) begin
        // Pause the sender once until every flag is back.
        if (p == 4 && it == 20) begin
          drain();
        end
        if ($urandom_range(0, 99) < 15) begin
          if (n > 0 && $urandom_range(0, 1) == 1) begin
            slot = $urandom_range(0, n - 1);
            load_vertex(slot, LatW'(near(shape_mid_lat, shape_span)),
                        LonW'(near(shape_mid_lon, shape_span)));
          end else begin
            slot = $urandom_range(0, MaxCorners - 1);
            load_vertex(slot, LatW'($urandom), LonW'($urandom));
          end
        end else begin
          pick_point(n, la, lo);
          send_item(ActTest, VidxW'($urandom), la, lo);
        end
      end
    end

    // Wait out every flag and the back end, then give the verdict.
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
